### sv/pcp_pkg.sv
`timescale 1ns / 1ps
package pcp_pkg;

  localparam int NumCoeffs = 5;
  localparam int AngleBits = 24;
  localparam int BinAngBits = 33;
  localparam int BackDepth = 25;

  localparam logic [2:0] CfgNumPeriods = 3'd0;
  localparam logic [2:0] CfgOrdMax = 3'd1;
  localparam logic [2:0] CfgOrdMin = 3'd2;
  localparam logic [2:0] CfgCoef0 = 3'd3;
  localparam logic [2:0] CfgCoef4 = 3'd7;

  localparam logic ReqValue = 1'b0;
  localparam logic ReqDeriv = 1'b1;

  typedef struct packed {
    logic [7:0]                  num_periods;
    logic [2:0]                  ord_max;
    logic [2:0]                  ord_min;
    logic [NumCoeffs-1:0][31:0]  coef;
  } cfg_t;

  // one queue entry: request after phase folding
  typedef struct packed {
    logic        req_type;
    logic [2:0]  coef_index;
    logic        mirror;
    logic [AngleBits:0] angle;
  } qent_t;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  coef_index;
    logic        mirror;
  } side_t;

  // odd sine polynomial, Q30
  function automatic logic signed [33:0] sin_coef(input int k);
    logic signed [33:0] c;
    case (k)
      0: c = 34'sd1686629713;
      1: c = -34'sd693598668;
      2: c = 34'sd85569305;
      3: c = -34'sd5026997;
      4: c = 34'sd172272;
      5: c = -34'sd3864;
      default: c = 34'sd61;
    endcase
    return c;
  endfunction

endpackage

### sv/pcp_if.sv
`timescale 1ns / 1ps
interface pcp_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [23:0] arc_angle;
  logic [2:0]  coef_index;
  modport source (output valid, req_type, arc_angle, coef_index, input ready);
  modport sink (input valid, req_type, arc_angle, coef_index, output ready);
endinterface

interface pcp_res_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] result_value;
  logic               saturated;
  modport source (output valid, result_value, saturated, input ready);
  modport sink (input valid, result_value, saturated, output ready);
endinterface

### sv/pcp_front.sv
`timescale 1ns / 1ps
module pcp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     num_periods_i,
  pcp_req_if.sink        req_i,
  output logic           push_valid_o,
  input  logic           push_ready_i,
  output pcp_pkg::qent_t push_data_o
);
  import pcp_pkg::*;

  logic                 f_v_q;
  logic                 f_req_q;
  logic [2:0]           f_idx_q;
  logic [AngleBits-1:0] f_p_q;
  logic [AngleBits-1:0] p_d;
  logic                 mirror;
  localparam logic [AngleBits:0] Half = (AngleBits+1)'(1) << (AngleBits - 1);

  assign req_i.ready = !f_v_q || push_ready_i;
  assign p_d = AngleBits'(32'(num_periods_i) * 32'(req_i.arc_angle));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (req_i.ready) begin
      f_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      f_req_q <= req_i.req_type;
      f_idx_q <= req_i.coef_index;
      f_p_q   <= p_d;
    end
  end

  // past the half turn the argument wraps negative
  assign mirror = {1'b0, f_p_q} > Half;
  assign push_valid_o = f_v_q;
  always_comb begin
    push_data_o.req_type   = f_req_q;
    push_data_o.coef_index = f_idx_q;
    push_data_o.mirror     = mirror;
    push_data_o.angle      = mirror ? (Half - {1'b0, f_p_q}) : {1'b0, f_p_q};
  end

endmodule

### sv/pcp_queue.sv
`timescale 1ns / 1ps
module pcp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pcp_pkg::qent_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output pcp_pkg::qent_t pop_data_o
);
  import pcp_pkg::*;

  qent_t      mem_q [2];
  logic       wp_q;
  logic       rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign push = push_valid_i && push_ready_o;
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid_o && !pop_i) |=> $stable(pop_data_o)) else $error("queue head changed");

endmodule

### sv/pcp_sin_lane.sv
`timescale 1ns / 1ps
module pcp_sin_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [pcp_pkg::BinAngBits-1:0] ang_i,
  output logic signed [31:0]            sin_o
);
  import pcp_pkg::*;

  logic [31:0]        xs_q   [7];
  logic [1:0]         quad_q [8];
  logic [30:0]        u_q    [6];
  logic signed [33:0] acc_q  [6];
  logic signed [35:0] rf_q;
  logic signed [31:0] s_q;
  logic [31:0]        x_d;
  logic [63:0]        xx;
  logic signed [66:0] fp;
  logic signed [35:0] r;

  // quadrant fold
  assign x_d = ang_i[31] ? (32'h8000_0000 - {1'b0, ang_i[30:0]}) : {1'b0, ang_i[30:0]};
  assign xx  = 64'(x_d) * 64'(x_d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]   <= x_d;
      quad_q[0] <= ang_i[32:31];
      u_q[0]    <= xx[62:32];
    end
  end

  for (genvar s = 0; s < 6; s++) begin : g_horner
    logic signed [33:0] prev;
    logic signed [66:0] hp;
    if (s == 0) begin : g_first
      assign prev = sin_coef(6);
    end else begin : g_next
      assign prev = acc_q[s-1];
    end
    assign hp = prev * signed'({2'b00, u_q[s]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s]    <= sin_coef(5 - s) + 34'(hp >>> 30);
        xs_q[s+1]   <= xs_q[s];
        quad_q[s+1] <= quad_q[s];
        if (s < 5) u_q[(s < 5) ? s + 1 : s] <= u_q[s];
      end
    end
  end

  assign fp = acc_q[5] * signed'({1'b0, xs_q[6]});

  always_comb begin
    r = rf_q;
    if (rf_q < 36'sd0) r = 36'sd0;
    if (rf_q > 36'sd1073741824) r = 36'sd1073741824;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rf_q      <= 36'(fp >>> 31);
      quad_q[7] <= quad_q[6];
      s_q       <= quad_q[7][1] ? -32'(r) : 32'(r);
    end
  end

  assign sin_o = s_q;

endmodule

### sv/pcp_back.sv
`timescale 1ns / 1ps
module pcp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pcp_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  pcp_pkg::qent_t q_data_i,
  output logic           q_pop_o,
  pcp_res_if.source      res_o
);
  import pcp_pkg::*;

  localparam int Lanes = NumCoeffs + 1;
  localparam logic [BinAngBits-1:0] Qtr = BinAngBits'(1) << 31;

  logic                   en;
  logic [BackDepth-1:0]   vld_q;
  side_t                  sb_q [BackDepth-1];
  logic [BinAngBits-1:0]  ang [Lanes];
  logic signed [31:0]     sn [Lanes];
  logic signed [63:0]     tp [NumCoeffs-1];
  logic signed [32:0]     term_q [NumCoeffs-1];
  logic signed [25:0]     dx_q;
  logic signed [25:0]     dx_d;
  logic signed [34:0]     x_q;
  logic signed [34:0]     xd_q [12];
  logic signed [31:0]     zc_q [14];
  logic signed [31:0]     shc_q [14];
  logic signed [31:0]     chc_q [14];
  logic signed [31:0]     z28;
  logic signed [48:0]     plo_q;
  logic signed [50:0]     phi_q;
  logic signed [63:0]     prod;
  logic signed [63:0]     res64;
  logic signed [39:0]     res_q;
  logic                   sat_q;
  logic [3:0]             ord_sum;

  assign en      = !res_o.valid || res_o.ready;
  assign q_pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BackDepth-2:0], q_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= '{req_type: q_data_i.req_type, coef_index: q_data_i.coef_index,
                   mirror: q_data_i.mirror};
      for (int i = 1; i < BackDepth - 1; i++) sb_q[i] <= sb_q[i-1];
    end
  end

  // half angle for the zero factor, harmonic phases for the series
  always_comb begin
    ang[0] = {q_data_i.angle, 8'b0};
    ang[1] = {q_data_i.angle, 8'b0} + Qtr;
    for (int k = 1; k < Lanes - 1; k++) begin
      ang[k+1] = {AngleBits'(q_data_i.angle[AngleBits-1:0] * AngleBits'(k)), 9'b0} + Qtr;
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    pcp_sin_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .ang_i (ang[l]),
      .sin_o (sn[l])
    );
  end

  always_comb begin
    for (int i = 0; i < NumCoeffs - 1; i++) begin
      tp[i] = signed'(cfg_i.coef[i+1]) * sn[i+2];
    end
    case (sb_q[8].coef_index)
      3'd0: dx_d = 26'sd16777216;
      3'd1: dx_d = 26'((sn[2] + 32'sd32) >>> 6);
      3'd2: dx_d = 26'((sn[3] + 32'sd32) >>> 6);
      3'd3: dx_d = 26'((sn[4] + 32'sd32) >>> 6);
      3'd4: dx_d = 26'((sn[5] + 32'sd32) >>> 6);
      default: dx_d = 26'sd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumCoeffs - 1; i++) begin
        term_q[i] <= 33'((tp[i] + 64'sd536870912) >>> 30);
      end
      dx_q <= dx_d;
      if (sb_q[9].req_type == ReqDeriv) begin
        x_q <= 35'(dx_q);
      end else begin
        x_q <= 35'(signed'(cfg_i.coef[0])) + 35'(term_q[0]) + 35'(term_q[1])
             + 35'(term_q[2]) + 35'(term_q[3]);
      end
      xd_q[0] <= x_q;
      for (int i = 1; i < 12; i++) xd_q[i] <= xd_q[i-1];
    end
  end

  // zero factor: sin powers first, then cos powers
  assign ord_sum = {1'b0, cfg_i.ord_max} + {1'b0, cfg_i.ord_min};

  for (genvar j = 0; j < 14; j++) begin : g_zero
    logic signed [31:0] zp, shp, chp, f;
    logic signed [63:0] zm;
    if (j == 0) begin : g_first
      assign zp  = 32'sd1073741824;
      assign shp = sn[0];
      assign chp = sn[1];
    end else begin : g_next
      assign zp  = zc_q[j-1];
      assign shp = shc_q[j-1];
      assign chp = chc_q[j-1];
    end
    assign f  = (4'(j) < {1'b0, cfg_i.ord_max}) ? shp : chp;
    assign zm = zp * f;
    always_ff @(posedge clk_i) begin
      if (en) begin
        shc_q[j] <= shp;
        chc_q[j] <= chp;
        zc_q[j]  <= (4'(j) < ord_sum) ? 32'((zm + 64'sd536870912) >>> 30) : zp;
      end
    end
  end

  assign z28 = (zc_q[13] + 32'sd2) >>> 2;

  always_comb begin
    prod  = (64'(phi_q) <<< 16) + 64'(plo_q);
    res64 = (prod + 64'sd134217728) >>> 28;
    if (sb_q[23].req_type == ReqDeriv && sb_q[23].mirror) res64 = -res64;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      plo_q <= signed'({1'b0, xd_q[11][15:0]}) * z28;
      phi_q <= signed'(xd_q[11][34:16]) * z28;
      if (res64 > 64'sd549755813887) begin
        res_q <= 40'sh7f_ffff_ffff;
        sat_q <= 1'b1;
      end else if (res64 < -64'sd549755813888) begin
        res_q <= 40'sh80_0000_0000;
        sat_q <= 1'b1;
      end else begin
        res_q <= 40'(res64);
        sat_q <= 1'b0;
      end
    end
  end

  assign res_o.valid        = vld_q[BackDepth-1];
  assign res_o.result_value = res_q;
  assign res_o.saturated    = sat_q;

  a_pop_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> en) else $error("pop while stalled");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> $stable(vld_q) && $stable(res_q))
    else $error("pipeline moved while stalled");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> vld_q[0] == $past(q_valid_i)) else $error("item lost at back entry");

endmodule

### sv/periodic_curvature_profile_eval.sv
`timescale 1ns / 1ps
// Curvature profile evaluator: each request (value or coefficient derivative at an
// arc angle) gives one Q16.24 result. One request is taken per cycle while the output
// is not stalled; a result passes the front register and the two-entry queue, then
// the 25-stage back pipeline of six sine lanes, the 14-step zero-factor multiply chain and a
// split final product. A stalled output halts the back pipeline and the two-entry
// queue absorbs the front. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while no request is in flight; the user must ensure this, the block does not.
module periodic_curvature_profile_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pcp_req_if.sink     req_i,
  pcp_res_if.source   res_o
);
  import pcp_pkg::*;

  cfg_t  cfg_q;
  logic  push_valid;
  logic  push_ready;
  qent_t push_data;
  logic  pop_valid;
  logic  pop;
  qent_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{num_periods: 8'd1, ord_max: 3'd0, ord_min: 3'd0, coef: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNumPeriods: cfg_q.num_periods <= cfg_data_i[7:0];
        CfgOrdMax:     cfg_q.ord_max <= cfg_data_i[2:0];
        CfgOrdMin:     cfg_q.ord_min <= cfg_data_i[2:0];
        default: begin
          if (cfg_idx_i inside {[CfgCoef0:CfgCoef4]}) begin
            cfg_q.coef[3'(cfg_idx_i - CfgCoef0)] <= cfg_data_i;
          end
        end
      endcase
    end
  end

  pcp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .num_periods_i (cfg_q.num_periods),
    .req_i         (req_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  pcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  pcp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (pop_valid),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .res_o     (res_o)
  );

endmodule
